/* rtl/cnls_pkg.sv */
package cnls_pkg;

  // Default seat table depth
  localparam int SEATS_DEF = 16;

  // Field widths
  localparam int ID_W   = 11;
  localparam int SIL_W  = 16;
  localparam int TXP_W  = 8;
  localparam int CFGD_W = 16;
  localparam int CFGI_W = 3;

  // Heartbeat frame markers in data bytes 1 and 2
  localparam logic [7:0] HB_MARK1 = 8'h01;
  localparam logic [7:0] HB_MARK2 = 8'h55;

  // Register reset values
  localparam logic [TXP_W-1:0] TX_PERIOD_RST  = 8'd200;
  localparam logic [ID_W-1:0]  HB_BASE_RST    = 11'd512;
  localparam logic [ID_W-1:0]  NM_ID_RST      = 11'd0;
  localparam logic [ID_W-1:0]  STATUS_ID_RST  = 11'd0;
  localparam logic [SIL_W-1:0] NM_TMO_RST     = 16'd250;
  localparam logic [SIL_W-1:0] STATUS_TMO_RST = 16'd50;
  localparam logic [SIL_W-1:0] LOSS_LIM_RST   = 16'd1000;

  // Configuration register indexes
  typedef enum logic [CFGI_W-1:0] {
    CFG_TX_PERIOD   = 3'd0,
    CFG_HB_BASE     = 3'd1,
    CFG_NM_ID       = 3'd2,
    CFG_STATUS_ID   = 3'd3,
    CFG_NM_TMO      = 3'd4,
    CFG_STATUS_TMO  = 3'd5,
    CFG_LOSS_LIM    = 3'd6
  } cfg_idx_t;

  // Input operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } state_t;

  // One seat store entry
  typedef struct packed {
    logic             fresh;
    logic [SIL_W-1:0] silence;
    logic [ID_W-1:0]  id;
  } seat_t;

  // Saturating increment of a silence counter
  function automatic logic [SIL_W-1:0] sat_inc(input logic [SIL_W-1:0] v);
    return (v == {SIL_W{1'b1}}) ? v : v + SIL_W'(1);
  endfunction

endpackage

/* rtl/can_node_liveness_supervisor.sv */
// CAN node liveness supervisor.
// Input channel (in_valid/in_ready): one operation per transfer. in_op selects
// a tick, a received frame (in_frame_id, in_payload_byte1/2) or a read of a
// seat's stored id (in_seat_index). Each transfer yields exactly one result on
// the output channel (out_valid/out_ready); fields that do not apply are 0.
// Configuration: cfg_we writes cfg_wdata into register cfg_index;
// write only while no operation is in flight.
// Timing: a tick walks the seat store through its single memory port, one
// entry per cycle with write-back overlapped on the next read. An in-range
// read waits on one registered memory read; a frame needs none. in_ready
// returns as the result loads, so no operation is accepted while a tick sweeps.
// One operation is in flight at a time; in_ready is high whenever idle.
// The result sits in an output register, so the next operation is accepted
// while a result waits; a finished operation holds until that register frees.
// Reset (rst_n low, synchronous) restores register defaults, clears message
// and transmit state and marks every seat entry empty; no clearing pass.
module can_node_liveness_supervisor #(
  parameter int SEATS = cnls_pkg::SEATS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [cnls_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [cnls_pkg::CFGD_W-1:0]   cfg_wdata,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [cnls_pkg::ID_W-1:0]     in_frame_id,
  input  logic [7:0]                    in_payload_byte1,
  input  logic [7:0]                    in_payload_byte2,
  input  logic [3:0]                    in_seat_index,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_heartbeat_tx_due,
  output logic [1:0]                    out_rx_seen,
  output logic [1:0]                    out_rx_timeout,
  output logic [cnls_pkg::ID_W-1:0]     out_seat_id_value,
  output logic                          out_seat_out_of_range
);

  localparam int IDX_W = (SEATS > 1) ? $clog2(SEATS) : 1;
  localparam int CNT_W = $clog2(SEATS + 1);
  localparam int ID_W  = cnls_pkg::ID_W;
  localparam int SIL_W = cnls_pkg::SIL_W;

  // Configuration registers
  logic [cnls_pkg::TXP_W-1:0] tx_period_r;
  logic [ID_W-1:0]            hb_base_r;
  logic [ID_W-1:0]            nm_id_r;
  logic [ID_W-1:0]            status_id_r;
  logic [SIL_W-1:0]           nm_tmo_r;
  logic [SIL_W-1:0]           status_tmo_r;
  logic [SIL_W-1:0]           loss_lim_r;

  // Controller and small state
  cnls_pkg::state_t           state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       wb_pend_r, wb_pend_nxt;
  logic [IDX_W-1:0]           wb_idx_r, wb_idx_nxt;
  logic [cnls_pkg::TXP_W-1:0] tx_cd_r, tx_cd_nxt;
  logic [1:0]                 msg_pend_r, msg_pend_nxt;
  logic [SIL_W-1:0]           msg_sil_r [2];
  logic [SIL_W-1:0]           msg_sil_nxt [2];
  logic [SEATS-1:0]           seat_vld_r;

  // Pending result and output register
  logic                       res_due_r, res_due_nxt;
  logic [1:0]                 res_seen_r, res_seen_nxt;
  logic [1:0]                 res_tout_r, res_tout_nxt;
  logic [ID_W-1:0]            res_id_r, res_id_nxt;
  logic                       res_oor_r, res_oor_nxt;
  logic                       out_valid_r;
  logic                       out_due_r;
  logic [1:0]                 out_seen_r;
  logic [1:0]                 out_tout_r;
  logic [ID_W-1:0]            out_id_r;
  logic                       out_oor_r;
  logic                       out_load;

  // Seat store
  cnls_pkg::seat_t            seat_mem [SEATS];
  cnls_pkg::seat_t            mem_rd_r;
  logic                       rd_vld_r;
  logic                       mem_re;
  logic [IDX_W-1:0]           mem_raddr;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  cnls_pkg::seat_t            mem_wdata;

  logic                       accept;
  cnls_pkg::seat_t            rd_entry;
  cnls_pkg::seat_t            wb_entry;

  // Tick terms
  logic                       tx_due;
  logic [cnls_pkg::TXP_W-1:0] tx_load;
  logic [cnls_pkg::TXP_W-1:0] tx_cd_tick;
  logic [1:0]                 tick_seen;
  logic [1:0]                 tick_tout;
  logic [SIL_W-1:0]           tick_sil [2];
  logic [SIL_W-1:0]           msg_lim [2];

  // Frame and read terms
  logic                       hb_match;
  logic [ID_W-1:0]            seat_off;
  logic                       seat_in_rng;
  logic                       read_in_rng;

  assign in_ready = (state_r == cnls_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == cnls_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_period_r  <= cnls_pkg::TX_PERIOD_RST;
      hb_base_r    <= cnls_pkg::HB_BASE_RST;
      nm_id_r      <= cnls_pkg::NM_ID_RST;
      status_id_r  <= cnls_pkg::STATUS_ID_RST;
      nm_tmo_r     <= cnls_pkg::NM_TMO_RST;
      status_tmo_r <= cnls_pkg::STATUS_TMO_RST;
      loss_lim_r   <= cnls_pkg::LOSS_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cnls_pkg::CFG_TX_PERIOD:  tx_period_r  <= cfg_wdata[cnls_pkg::TXP_W-1:0];
        cnls_pkg::CFG_HB_BASE:    hb_base_r    <= cfg_wdata[ID_W-1:0];
        cnls_pkg::CFG_NM_ID:      nm_id_r      <= cfg_wdata[ID_W-1:0];
        cnls_pkg::CFG_STATUS_ID:  status_id_r  <= cfg_wdata[ID_W-1:0];
        cnls_pkg::CFG_NM_TMO:     nm_tmo_r     <= cfg_wdata[SIL_W-1:0];
        cnls_pkg::CFG_STATUS_TMO: status_tmo_r <= cfg_wdata[SIL_W-1:0];
        cnls_pkg::CFG_LOSS_LIM:   loss_lim_r   <= cfg_wdata[SIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick: transmit countdown and monitored message aging
  assign msg_lim[0] = nm_tmo_r;
  assign msg_lim[1] = status_tmo_r;

  always_comb begin
    tx_due     = (tx_cd_r == '0);
    tx_load    = tx_due ? tx_period_r : tx_cd_r;
    tx_cd_tick = (tx_load != '0) ? tx_load - cnls_pkg::TXP_W'(1) : tx_load;
    for (int i = 0; i < 2; i++) begin
      tick_seen[i] = msg_pend_r[i];
      tick_sil[i]  = cnls_pkg::sat_inc(msg_pend_r[i] ? '0 : msg_sil_r[i]);
      tick_tout[i] = (tick_sil[i] >= msg_lim[i]);
    end
  end

  // Frame: heartbeat match and seat offset; read range check
  assign hb_match    = ((in_frame_id & hb_base_r) == hb_base_r) &&
                       (in_payload_byte1 == cnls_pkg::HB_MARK1) &&
                       (in_payload_byte2 == cnls_pkg::HB_MARK2);
  assign seat_off    = in_frame_id - hb_base_r;
  assign seat_in_rng = (32'(seat_off) < SEATS);
  assign read_in_rng = (32'(in_seat_index) < SEATS);

  // Sweep write-back: an empty entry reads as all zero
  always_comb begin
    rd_entry         = rd_vld_r ? mem_rd_r : '0;
    wb_entry.fresh   = 1'b0;
    wb_entry.silence = rd_entry.fresh ? '0 : cnls_pkg::sat_inc(rd_entry.silence);
    wb_entry.id      = (wb_entry.silence >= loss_lim_r) ? '0 : rd_entry.id;
  end

  // Controller next state and memory port control
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    wb_pend_nxt  = wb_pend_r;
    wb_idx_nxt   = wb_idx_r;
    tx_cd_nxt    = tx_cd_r;
    msg_pend_nxt = msg_pend_r;
    msg_sil_nxt  = msg_sil_r;
    res_due_nxt  = res_due_r;
    res_seen_nxt = res_seen_r;
    res_tout_nxt = res_tout_r;
    res_id_nxt   = res_id_r;
    res_oor_nxt  = res_oor_r;
    mem_re       = 1'b0;
    mem_raddr    = cnt_r[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = wb_idx_r;
    mem_wdata    = wb_entry;

    unique case (state_r)
      cnls_pkg::ST_IDLE: begin
        if (accept) begin
          res_due_nxt  = 1'b0;
          res_seen_nxt = '0;
          res_tout_nxt = '0;
          res_id_nxt   = '0;
          res_oor_nxt  = 1'b0;
          unique case (in_op)
            cnls_pkg::OP_TICK: begin
              res_due_nxt  = tx_due;
              res_seen_nxt = tick_seen;
              res_tout_nxt = tick_tout;
              tx_cd_nxt    = tx_cd_tick;
              msg_pend_nxt = '0;
              msg_sil_nxt  = tick_sil;
              cnt_nxt      = '0;
              wb_pend_nxt  = 1'b0;
              state_nxt    = cnls_pkg::ST_SWEEP;
            end
            cnls_pkg::OP_FRAME: begin
              if (hb_match && seat_in_rng) begin
                mem_we          = 1'b1;
                mem_waddr       = IDX_W'(seat_off);
                mem_wdata.fresh   = 1'b1;
                mem_wdata.silence = '0;
                mem_wdata.id      = in_frame_id;
              end
              res_oor_nxt = hb_match && !seat_in_rng;
              if (in_frame_id == nm_id_r) msg_pend_nxt[0] = 1'b1;
              if (in_frame_id == status_id_r) msg_pend_nxt[1] = 1'b1;
              state_nxt = cnls_pkg::ST_DONE;
            end
            cnls_pkg::OP_READ: begin
              if (read_in_rng) begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(in_seat_index);
                state_nxt = cnls_pkg::ST_READ;
              end else begin
                state_nxt = cnls_pkg::ST_DONE;
              end
            end
            default: state_nxt = cnls_pkg::ST_DONE;
          endcase
        end
      end
      cnls_pkg::ST_SWEEP: begin
        // Read entry cnt_r while writing back the entry read last cycle
        if (cnt_r < CNT_W'(SEATS)) begin
          mem_re      = 1'b1;
          wb_pend_nxt = 1'b1;
          wb_idx_nxt  = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + CNT_W'(1);
        end else begin
          wb_pend_nxt = 1'b0;
          state_nxt   = cnls_pkg::ST_DONE;
        end
        mem_we = wb_pend_r;
      end
      cnls_pkg::ST_READ: begin
        res_id_nxt = rd_entry.id;
        state_nxt  = cnls_pkg::ST_DONE;
      end
      cnls_pkg::ST_DONE: begin
        if (out_load) state_nxt = cnls_pkg::ST_IDLE;
      end
      default: state_nxt = cnls_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cnls_pkg::ST_IDLE;
      cnt_r      <= '0;
      wb_pend_r  <= 1'b0;
      tx_cd_r    <= '0;
      msg_pend_r <= '0;
      msg_sil_r  <= '{default: '0};
      seat_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      wb_pend_r  <= wb_pend_nxt;
      tx_cd_r    <= tx_cd_nxt;
      msg_pend_r <= msg_pend_nxt;
      msg_sil_r  <= msg_sil_nxt;
      if (mem_we) seat_vld_r[mem_waddr] <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wb_idx_r   <= wb_idx_nxt;
    res_due_r  <= res_due_nxt;
    res_seen_r <= res_seen_nxt;
    res_tout_r <= res_tout_nxt;
    res_id_r   <= res_id_nxt;
    res_oor_r  <= res_oor_nxt;
    if (out_load) begin
      out_due_r  <= res_due_r;
      out_seen_r <= res_seen_r;
      out_tout_r <= res_tout_r;
      out_id_r   <= res_id_r;
      out_oor_r  <= res_oor_r;
    end
  end

  // Seat store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) seat_mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      mem_rd_r <= seat_mem[mem_raddr];
      rd_vld_r <= seat_vld_r[mem_raddr] && !(mem_we && (mem_waddr == mem_raddr));
    end
  end

  assign out_valid             = out_valid_r;
  assign out_heartbeat_tx_due  = out_due_r;
  assign out_rx_seen           = out_seen_r;
  assign out_rx_timeout        = out_tout_r;
  assign out_seat_id_value     = out_id_r;
  assign out_seat_out_of_range = out_oor_r;

  // Sweep never writes the entry it reads in the same cycle
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("seat store read and write collide");

  // A tick transfer starts the sweep at entry zero
  a_tick_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == cnls_pkg::OP_TICK)) |=>
      ((state_r == cnls_pkg::ST_SWEEP) && (cnt_r == '0) && !wb_pend_r))
    else $error("tick did not start sweep");

  // A finished operation lands in the output register and frees the input
  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && (state_r == cnls_pkg::ST_IDLE)))
    else $error("result not delivered");

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnls_pkg::*;

  localparam int SEAT_CNT = SEATS_DEF;
  // op value with no meaning: block must leave state alone and reply all zero
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * (SEAT_CNT + 3);

  typedef struct {
    logic [1:0]      op;
    logic [ID_W-1:0] frame_id;
    logic [7:0]      byte1;
    logic [7:0]      byte2;
    logic [3:0]      seat_index;
  } bus_event_t;

  typedef struct {
    logic            hb_due;
    logic [1:0]      seen;
    logic [1:0]      tout;
    logic [ID_W-1:0] seat_id;
    logic            oor;
  } liveness_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we = 1'b0;
  logic [CFGI_W-1:0]   cfg_index = CFG_TX_PERIOD;
  logic [CFGD_W-1:0]   cfg_wdata = '0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_op = OP_TICK;
  logic [ID_W-1:0]     in_frame_id = '0;
  logic [7:0]          in_payload_byte1 = '0;
  logic [7:0]          in_payload_byte2 = '0;
  logic [3:0]          in_seat_index = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_heartbeat_tx_due;
  logic [1:0]          out_rx_seen;
  logic [1:0]          out_rx_timeout;
  logic [ID_W-1:0]     out_seat_id_value;
  logic                out_seat_out_of_range;

  can_node_liveness_supervisor #(.SEATS(SEAT_CNT)) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_frame_id           (in_frame_id),
    .in_payload_byte1      (in_payload_byte1),
    .in_payload_byte2      (in_payload_byte2),
    .in_seat_index         (in_seat_index),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_heartbeat_tx_due  (out_heartbeat_tx_due),
    .out_rx_seen           (out_rx_seen),
    .out_rx_timeout        (out_rx_timeout),
    .out_seat_id_value     (out_seat_id_value),
    .out_seat_out_of_range (out_seat_out_of_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register mirror
  logic [TXP_W-1:0] tx_period_r;
  logic [ID_W-1:0]  hb_base_r;
  logic [ID_W-1:0]  nm_id_r;
  logic [ID_W-1:0]  status_id_r;
  logic [SIL_W-1:0] nm_tmo_r;
  logic [SIL_W-1:0] status_tmo_r;
  logic [SIL_W-1:0] loss_lim_r;

  // Supervisor state mirror
  logic             seat_fresh_m [SEAT_CNT];
  logic [SIL_W-1:0] seat_sil_m   [SEAT_CNT];
  logic [ID_W-1:0]  seat_id_m    [SEAT_CNT];
  logic             msg_pend_m   [2];
  logic [SIL_W-1:0] msg_sil_m    [2];
  logic [TXP_W-1:0] tx_count_m;

  bus_event_t      bus_events[$];
  liveness_reply_t supervisor_replies[$];
  bus_event_t      cur_event;
  liveness_reply_t got_reply;
  liveness_reply_t want_reply;

  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned err_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_req_q = 1'b0;
  logic        src_idle_on = 1'b1;
  logic        snk_idle_on = 1'b1;

  function automatic logic [SIL_W-1:0] silence_step(input logic [SIL_W-1:0] v);
    return (v == {SIL_W{1'b1}}) ? v : v + SIL_W'(1);
  endfunction

  // Advance the supervisor mirror by one event and return its reply
  function automatic liveness_reply_t supervise_step(input bus_event_t ev);
    liveness_reply_t r;
    logic [SIL_W-1:0] lim [2];
    int unsigned seat;
    r = '{default: '0};
    lim[0] = nm_tmo_r;
    lim[1] = status_tmo_r;
    case (ev.op)
      OP_TICK: begin
        if (tx_count_m == 0) begin
          tx_count_m = tx_period_r;
          r.hb_due = 1'b1;
        end
        if (tx_count_m != 0) tx_count_m = tx_count_m - TXP_W'(1);
        for (int i = 0; i < 2; i++) begin
          if (msg_pend_m[i]) begin
            msg_pend_m[i] = 1'b0;
            msg_sil_m[i] = '0;
            r.seen[i] = 1'b1;
          end
          msg_sil_m[i] = silence_step(msg_sil_m[i]);
          if (msg_sil_m[i] >= lim[i]) r.tout[i] = 1'b1;
        end
        for (int i = 0; i < SEAT_CNT; i++) begin
          if (seat_fresh_m[i]) begin
            seat_fresh_m[i] = 1'b0;
            seat_sil_m[i] = '0;
          end else begin
            seat_sil_m[i] = silence_step(seat_sil_m[i]);
          end
          if (seat_sil_m[i] >= loss_lim_r) seat_id_m[i] = '0;
        end
      end
      OP_FRAME: begin
        if ((ev.frame_id & hb_base_r) == hb_base_r && ev.byte1 == HB_MARK1 &&
            ev.byte2 == HB_MARK2) begin
          seat = 32'(ev.frame_id) - 32'(hb_base_r);
          if (seat < SEAT_CNT) begin
            seat_fresh_m[seat] = 1'b1;
            seat_id_m[seat] = ev.frame_id;
          end else begin
            r.oor = 1'b1;
          end
        end
        if (ev.frame_id == nm_id_r) msg_pend_m[0] = 1'b1;
        if (ev.frame_id == status_id_r) msg_pend_m[1] = 1'b1;
      end
      OP_READ: begin
        if (ev.seat_index < SEAT_CNT) r.seat_id = seat_id_m[ev.seat_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic push_event(input logic [1:0] op, input logic [ID_W-1:0] fid,
                            input logic [7:0] b1, input logic [7:0] b2,
                            input logic [3:0] sidx);
    bus_events.push_back('{op, fid, b1, b2, sidx});
    queued_total++;
  endtask

  // Random traffic: mostly ticks, heartbeats and watched ids, some noise
  task automatic queue_random(input int n);
    bus_event_t ev;
    int unsigned roll;
    logic [ID_W-1:0] s;
    for (int k = 0; k < n; k++) begin
      ev.frame_id = ID_W'($urandom);
      ev.byte1 = 8'($urandom);
      ev.byte2 = 8'($urandom);
      ev.seat_index = 4'($urandom);
      roll = $urandom_range(99);
      if (roll < 35) begin
        ev.op = OP_TICK;
      end else if (roll < 62) begin
        ev.op = OP_FRAME;
        s = ($urandom_range(99) < 80) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
        ev.frame_id = hb_base_r | (s & ~hb_base_r);
        ev.byte1 = HB_MARK1;
        ev.byte2 = HB_MARK2;
        // near miss: one marker byte off
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1)) ev.byte1 = 8'($urandom);
          else ev.byte2 = 8'($urandom);
        end
      end else if (roll < 74) begin
        ev.op = OP_FRAME;
        ev.frame_id = $urandom_range(1) ? nm_id_r : status_id_r;
        if ($urandom_range(3) == 0) begin
          ev.byte1 = HB_MARK1;
          ev.byte2 = HB_MARK2;
        end
      end else if (roll < 82) begin
        ev.op = OP_FRAME;
      end else if (roll < 97) begin
        ev.op = OP_READ;
      end else begin
        ev.op = OP_UNUSED;
      end
      bus_events.push_back(ev);
      queued_total++;
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFGD_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TX_PERIOD:  tx_period_r = val[TXP_W-1:0];
      CFG_HB_BASE:    hb_base_r = val[ID_W-1:0];
      CFG_NM_ID:      nm_id_r = val[ID_W-1:0];
      CFG_STATUS_ID:  status_id_r = val[ID_W-1:0];
      CFG_NM_TMO:     nm_tmo_r = val;
      CFG_STATUS_TMO: status_tmo_r = val;
      CFG_LOSS_LIM:   loss_lim_r = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int tx, input int base, input int nm,
                                input int st, input int nm_tmo, input int st_tmo,
                                input int loss);
    write_reg(CFG_TX_PERIOD, CFGD_W'(tx));
    write_reg(CFG_HB_BASE, CFGD_W'(base));
    write_reg(CFG_NM_ID, CFGD_W'(nm));
    write_reg(CFG_STATUS_ID, CFGD_W'(st));
    write_reg(CFG_NM_TMO, CFGD_W'(nm_tmo));
    write_reg(CFG_STATUS_TMO, CFGD_W'(st_tmo));
    write_reg(CFG_LOSS_LIM, CFGD_W'(loss));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block is idle once every queued event went through and every reply came back
  task automatic wait_drained();
    wait (accepted_total == queued_total && supervisor_replies.size() == 0);
    @(posedge clk);
  endtask

  // Input driver: one transfer per accepted event, random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        supervisor_replies.push_back(supervise_step(cur_event));
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (bus_events.size() > 0) begin
          cur_event = bus_events.pop_front();
          in_op <= cur_event.op;
          in_frame_id <= cur_event.frame_id;
          in_payload_byte1 <= cur_event.byte1;
          in_payload_byte2 <= cur_event.byte2;
          in_seat_index <= cur_event.seat_index;
          in_valid <= 1'b1;
          src_gap = src_idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side ready: random stalls plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap = 0;
      hold_left = 0;
      hold_req_q = 1'b0;
    end else begin
      if (hold_req && !hold_req_q) hold_left = LONG_HOLD;
      hold_req_q = hold_req;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (snk_idle_on && out_valid && out_ready) sink_gap = pick_gap();
      end
    end
  end

  // Reply checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_reply = '{out_heartbeat_tx_due, out_rx_seen, out_rx_timeout,
                    out_seat_id_value, out_seat_out_of_range};
      if (supervisor_replies.size() == 0) begin
        report_mismatch("reply with nothing outstanding", 1, 0);
      end else begin
        want_reply = supervisor_replies.pop_front();
        if (got_reply.hb_due !== want_reply.hb_due)
          report_mismatch("heartbeat_tx_due", got_reply.hb_due, want_reply.hb_due);
        if (got_reply.seen !== want_reply.seen)
          report_mismatch("rx_seen", got_reply.seen, want_reply.seen);
        if (got_reply.tout !== want_reply.tout)
          report_mismatch("rx_timeout", got_reply.tout, want_reply.tout);
        if (got_reply.seat_id !== want_reply.seat_id)
          report_mismatch("seat_id_value", got_reply.seat_id, want_reply.seat_id);
        if (got_reply.oor !== want_reply.oor)
          report_mismatch("seat_out_of_range", got_reply.oor, want_reply.oor);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sequence: reset, directed events, then random phases over several settings
  initial begin
    tx_period_r = TX_PERIOD_RST;
    hb_base_r = HB_BASE_RST;
    nm_id_r = NM_ID_RST;
    status_id_r = STATUS_ID_RST;
    nm_tmo_r = NM_TMO_RST;
    status_tmo_r = STATUS_TMO_RST;
    loss_lim_r = LOSS_LIM_RST;
    for (int i = 0; i < SEAT_CNT; i++) begin
      seat_fresh_m[i] = 1'b0;
      seat_sil_m[i] = '0;
      seat_id_m[i] = '0;
    end
    for (int i = 0; i < 2; i++) begin
      msg_pend_m[i] = 1'b0;
      msg_sil_m[i] = '0;
    end
    tx_count_m = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, base 512, both watched ids are 0
    @(negedge clk);
    push_event(OP_TICK, 11'h7FF, 8'hFF, 8'hFF, 4'hF);       // first tick requests a send
    push_event(OP_FRAME, 11'd512, HB_MARK1, HB_MARK2, 4'h0); // seat 0
    push_event(OP_FRAME, 11'd527, HB_MARK1, HB_MARK2, 4'hF); // seat 15
    push_event(OP_FRAME, 11'h7FF, HB_MARK1, HB_MARK2, 4'h0); // seat beyond table
    push_event(OP_FRAME, 11'd520, 8'h00, HB_MARK2, 4'h0);    // byte1 wrong
    push_event(OP_FRAME, 11'd521, HB_MARK1, 8'hFF, 4'h0);    // byte2 wrong
    push_event(OP_FRAME, 11'd3, HB_MARK1, HB_MARK2, 4'h0);   // base bits missing
    push_event(OP_READ, 11'd0, 8'h00, 8'h00, 4'h0);
    push_event(OP_READ, 11'h7FF, 8'hFF, 8'hFF, 4'hF);
    push_event(OP_READ, 11'd0, 8'h00, 8'h00, 4'h8);
    push_event(OP_FRAME, 11'd0, 8'hFF, 8'h00, 4'h5);         // matches both watched ids
    push_event(OP_TICK, 11'd0, 8'h00, 8'h00, 4'h0);          // both seen
    push_event(OP_TICK, 11'd0, 8'h00, 8'h00, 4'h0);
    push_event(OP_UNUSED, 11'h7FF, 8'hFF, 8'hFF, 4'hF);
    push_event(OP_UNUSED, 11'd0, 8'h00, 8'h00, 4'h0);
    push_event(OP_READ, 11'd0, 8'h00, 8'h00, 4'hF);
    wait_drained();

    // Default settings, some random traffic
    @(negedge clk);
    queue_random(60);
    wait_drained();

    // All zero limits, no idling on either side
    src_idle_on <= 1'b0;
    snk_idle_on <= 1'b0;
    apply_settings(0, 512, 11'h123, 11'h124, 0, 0, 0);
    @(negedge clk);
    queue_random(160);
    wait_drained();

    // Maximum settings; heartbeat id and both watched ids coincide
    src_idle_on <= 1'b1;
    snk_idle_on <= 1'b1;
    apply_settings(255, 2047, 2047, 2047, 65535, 65535, 65535);
    @(negedge clk);
    queue_random(150);
    wait_drained();

    // Base 0: seat equals frame id; short limits, sender never idles
    src_idle_on <= 1'b0;
    apply_settings(3, 0, 5, 7, 4, 6, 5);
    @(negedge clk);
    queue_random(160);
    wait_drained();

    // Random settings with short limits
    src_idle_on <= 1'b1;
    apply_settings($urandom_range(1, 12), $urandom_range(1, 127) << 4,
                   $urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(2, 30));
    @(negedge clk);
    queue_random(160);
    wait_drained();

    // Random settings again, with the receiver holding off for a long stretch
    apply_settings($urandom_range(1, 12), $urandom_range(1, 127) << 4,
                   $urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(2, 30));
    hold_req <= 1'b1;
    @(negedge clk);
    queue_random(160);
    wait_drained();

    // One-tick period, one id watched twice
    apply_settings(1, 11'h400, 11'h401, 11'h401, 8, 3, 12);
    @(negedge clk);
    queue_random(150);
    wait_drained();

    // Let any stray reply show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (supervisor_replies.size() != 0)
      report_mismatch("replies never delivered", 0, supervisor_replies.size());
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
